/* design/smavg_pkg.sv */
// Shared types and constants for the six-axis moving average core.
// No dependencies; used by every module of the block.
package smavg_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int AXES           = 6;
    localparam int TDATA_W        = SAMPLE_W * AXES;
    localparam int WINDOW_DEFAULT = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // pipeline control from the sequencer to the lanes and output stage
    typedef struct packed {
        logic accept;     // input word taken, history read and written
        logic move;       // stage one word moves into the output register
        logic old_valid;  // slot read by stage one word had been written
    } ctrl_t;

endpackage

/* design/smavg_ctrl.sv */
// Handshake sequencer: ring slot counter, slot valid bits, pipeline enables.
// Depends on smavg_pkg.
module smavg_ctrl #(
    parameter int WINDOW = smavg_pkg::WINDOW_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [$clog2(WINDOW)-1:0]  slot,
    output smavg_pkg::ctrl_t           ctrl
);

    localparam int SLOT_W = $clog2(WINDOW);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WINDOW-1:0] valid_reg;
    logic              old_valid_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept, move;

    assign move     = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || move;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        slot_next = slot_reg;
        if (accept)
        begin
            if (slot_reg == SLOT_W'(WINDOW - 1))
                slot_next = '0;
            else
                slot_next = slot_reg + SLOT_W'(1);
        end
        s1_valid_next  = accept || (s1_valid_reg && !move);
        out_valid_next = move || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                old_valid_reg       <= valid_reg[slot_reg];
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    assign slot           = slot_reg;
    assign m_tvalid       = out_valid_reg;
    assign ctrl.accept    = accept;
    assign ctrl.move      = move;
    assign ctrl.old_valid = old_valid_reg;

endmodule

/* design/smavg_lane.sv */
// One axis: history ring memory, running sum and floor mean.
// Depends on smavg_pkg.
module smavg_lane #(
    parameter int WINDOW = smavg_pkg::WINDOW_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  smavg_pkg::ctrl_t           ctrl,
    input  logic [$clog2(WINDOW)-1:0]  slot,
    input  smavg_pkg::sample_t         sample,
    output smavg_pkg::sample_t         mean
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = smavg_pkg::SAMPLE_W + SLOT_W;

    smavg_pkg::sample_t hist [WINDOW];
    smavg_pkg::sample_t old_reg;
    smavg_pkg::sample_t new_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] old_ext, new_ext;

    // read-before-write: old_reg takes the sample being replaced
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            hist[slot] <= sample;
            old_reg    <= hist[slot];
            new_reg    <= sample;
        end
    end

    always_comb
    begin
        old_ext  = ctrl.old_valid ? {{SLOT_W{old_reg[smavg_pkg::SAMPLE_W-1]}}, old_reg}
                                  : '0;
        new_ext  = {{SLOT_W{new_reg[smavg_pkg::SAMPLE_W-1]}}, new_reg};
        sum_next = sum_reg - old_ext + new_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (ctrl.move)
            sum_reg <= sum_next;
    end

    // arithmetic shift by log2(WINDOW): floor division
    assign mean = smavg_pkg::sample_t'(sum_next[SLOT_W +: smavg_pkg::SAMPLE_W]);

endmodule

/* design/smavg_merge.sv */
// Output stage: gathers the six lane means into the output data register.
// Depends on smavg_pkg.
module smavg_merge (
    input  logic                                clk,
    input  smavg_pkg::ctrl_t                    ctrl,
    input  smavg_pkg::sample_t                  means [smavg_pkg::AXES],
    output logic [smavg_pkg::TDATA_W-1:0]       tdata
);

    logic [smavg_pkg::TDATA_W-1:0] tdata_reg, tdata_next;

    always_comb
    begin
        tdata_next = '0;
        for (int i = 0; i < smavg_pkg::AXES; i++)
            tdata_next[i*smavg_pkg::SAMPLE_W +: smavg_pkg::SAMPLE_W] = means[i];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.move)
            tdata_reg <= tdata_next;
    end

    assign tdata = tdata_reg;

endmodule

/* design/six_axis_moving_average_core.sv */
// Six-axis boxcar filter top level: sequencer, six axis lanes, output stage.
// Depends on smavg_pkg, smavg_ctrl, smavg_lane, smavg_merge.
//
// Usage:
//   s_* channel takes one word per inertial sample (three accelerometer and
//   three gyroscope axes); m_* channel returns one word of six means per
//   sample, each the floor of the last WINDOW samples' sum over WINDOW.
//   Words are taken when tvalid and tready are both high.
// Pipeline: an accepted word is registered in stage one, then moves to the
//   output register, where m_tvalid rises and the result can be taken.
// Throughput: one word per cycle unless stalled; each lane reads and writes
//   its history memory once per word, the running sum one add and subtract.
// Reset: asynchronous, active low. Sums and slot counter clear at once;
//   history memories are not cleared, per-slot valid bits make unwritten
//   slots read as zero, so means ramp up over the first WINDOW words.
//   No clearing pass: the block takes input right after reset.
// Stall: a low m_tready keeps the output word; one further word waits in
//   the first stage, then s_tready falls until the output is taken.
// WINDOW must be a power of two from 2 to 256.
module six_axis_moving_average_core #(
    parameter int WINDOW = smavg_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z (16 bits each, lowest first)
    input  logic [smavg_pkg::TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // avg_acc_x, avg_acc_y, avg_acc_z, avg_gyro_x, avg_gyro_y, avg_gyro_z
    output logic [smavg_pkg::TDATA_W-1:0]     m_tdata
);

    localparam int SLOT_W = $clog2(WINDOW);

    smavg_pkg::ctrl_t   ctrl;
    logic [SLOT_W-1:0]  slot;
    smavg_pkg::sample_t means [smavg_pkg::AXES];

    smavg_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .slot     (slot),
        .ctrl     (ctrl)
    );

    for (genvar g = 0; g < smavg_pkg::AXES; g++)
    begin : g_lane
        smavg_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .slot   (slot),
            .sample (smavg_pkg::sample_t'(s_tdata[g*smavg_pkg::SAMPLE_W +:
                                                  smavg_pkg::SAMPLE_W])),
            .mean   (means[g])
        );
    end

    smavg_merge u_merge (
        .clk   (clk),
        .ctrl  (ctrl),
        .means (means),
        .tdata (m_tdata)
    );

endmodule
